/* src/ordered_list_store_defines.svh */
// Assertion macros shared by the ordered list store checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ORDERED_LIST_STORE_DEFINES_SVH
`define ORDERED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define OLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ols_pkg.sv */
// Package for the ordered list store: action codes, word types, default capacity.
// No dependencies; used by the top level and the checker.
package ols_pkg;

  // Default number of list entries
  localparam int unsigned CAPACITY_DEF = 32;

  // Action codes carried in the input word
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_SEARCH     = 3'd2,
    ACT_REMOVE     = 3'd3,
    ACT_PRINT      = 3'd4
  } ols_action_e;

  // Input word
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] operand_value;
  } ols_in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] entry_value;
    logic               entry_valid;
    logic               found;
    logic               overflow;
    logic               last;
  } ols_out_t;

endpackage

/* src/ols_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ols_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds when no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ordered_list_store.sv */
// Ordered list store: keeps up to CAPACITY signed 32-bit values in list order.
// Input word (valid/ready): action and operand. Actions: push front, push back,
// search, remove every match, print. Output word (valid/ready): one word per
// action, except print, which gives one word per entry, head first, with last
// set on the tail entry (an empty list prints one word with only last set).
// Entries live in a circular buffer in one RAM with head and tail pointers,
// so push front and push back take one write and no shifting.
// Timing: in_ready_o is high only while the sequencer is idle. A push or an
// unknown action goes to the finish state and gives its word once the output
// register is free. Search and remove walk the stored entries through the
// single RAM read port, one entry per cycle, then give their word from the
// finish state; remove compacts in the same pass through the RAM write port.
// Print gives one word per cycle while the receiver takes every word.
// A stalled receiver holds the output register and, during print, the walk.
// A finished word may wait at the output while the next input word is taken.
// Reset empties the list at once; RAM contents need no clearing.
// Depends on ols_pkg and ols_ram.
module ordered_list_store #(
  parameter int unsigned CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ols_pkg::ols_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ols_pkg::ols_out_t out_data_o
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [PW-1:0] LAST_PTR = PW'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  state_e            state_q, state_d;
  logic [PW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d, wr_cnt_q, wr_cnt_d;
  logic              dv_q, dv_d;
  logic [2:0]        act_q, act_d;
  logic [31:0]       opnd_q, opnd_d;
  logic              found_q, found_d, ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  ols_pkg::ols_out_t out_q, out_d;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic slot_free, in_acc, is_print, advance, issue, keep;

  ols_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  // Handshake and walk control
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign is_print  = (act_q == ols_pkg::ACT_PRINT);
  assign advance   = (state_q == ST_WALK) && (!dv_q || !is_print || slot_free);
  assign issue     = advance && (rd_idx_q != count_q);
  assign keep      = dv_q && (ram_rdata != opnd_q);
  assign ram_re    = issue;

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    rd_idx_d    = rd_idx_q;
    wr_cnt_d    = wr_cnt_q;
    dv_d        = dv_q;
    act_d       = act_q;
    opnd_d      = opnd_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = tail_q;
    ram_wdata   = in_data_i.operand_value;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_d    = in_data_i.action;
          opnd_d   = in_data_i.operand_value;
          found_d  = 1'b0;
          ovf_d    = 1'b0;
          rd_ptr_d = head_q;
          wr_ptr_d = head_q;
          rd_idx_d = '0;
          wr_cnt_d = '0;
          dv_d     = 1'b0;
          state_d  = ST_FINISH;
          case (in_data_i.action)
            ols_pkg::ACT_PUSH_FRONT: begin
              if (count_q == CAP_C) begin
                ovf_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ptr_dec(head_q);
                head_d    = ptr_dec(head_q);
                count_d   = count_q + 1'b1;
              end
            end
            ols_pkg::ACT_PUSH_BACK: begin
              if (count_q == CAP_C) begin
                ovf_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = tail_q;
                tail_d    = ptr_inc(tail_q);
                count_d   = count_q + 1'b1;
              end
            end
            ols_pkg::ACT_SEARCH, ols_pkg::ACT_REMOVE: begin
              state_d = ST_WALK;
            end
            ols_pkg::ACT_PRINT: begin
              if (count_q != '0) begin
                state_d = ST_WALK;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (advance) begin
          // Issue the next read, if any entries remain
          dv_d = issue;
          if (issue) begin
            rd_ptr_d = ptr_inc(rd_ptr_q);
            rd_idx_d = rd_idx_q + 1'b1;
          end
          // Consume the entry fetched by the last issued read
          if (dv_q) begin
            case (act_q)
              ols_pkg::ACT_SEARCH: begin
                if (ram_rdata == opnd_q) begin
                  found_d = 1'b1;
                end
              end
              ols_pkg::ACT_REMOVE: begin
                if (keep) begin
                  ram_we    = 1'b1;
                  ram_waddr = wr_ptr_q;
                  ram_wdata = ram_rdata;
                  wr_ptr_d  = ptr_inc(wr_ptr_q);
                  wr_cnt_d  = wr_cnt_q + 1'b1;
                end
              end
              ols_pkg::ACT_PRINT: begin
                out_valid_d       = 1'b1;
                out_d.entry_value = ram_rdata;
                out_d.entry_valid = 1'b1;
                out_d.found       = 1'b0;
                out_d.overflow    = 1'b0;
                out_d.last        = (rd_idx_q == count_q);
              end
              default: begin
              end
            endcase
          end
          // All entries consumed: close the walk
          if (!issue) begin
            if (is_print) begin
              state_d = ST_IDLE;
            end else begin
              state_d = ST_FINISH;
              if (act_q == ols_pkg::ACT_REMOVE) begin
                count_d = wr_cnt_d;
                tail_d  = wr_ptr_d;
              end
            end
          end
        end
      end

      ST_FINISH: begin
        // Hand out the single closing word once the output register is free
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.entry_value = '0;
          out_d.entry_valid = 1'b0;
          out_d.found       = found_q;
          out_d.overflow    = ovf_q;
          out_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      rd_idx_q    <= '0;
      wr_cnt_q    <= '0;
      dv_q        <= 1'b0;
      act_q       <= '0;
      opnd_q      <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_idx_q    <= rd_idx_d;
      wr_cnt_q    <= wr_cnt_d;
      dv_q        <= dv_d;
      act_q       <= act_d;
      opnd_q      <= opnd_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/ols_checker.sv */
// Port-level checker for the ordered list store, bound to the top level.
// Depends on ols_pkg and ordered_list_store_defines.svh.
`include "ordered_list_store_defines.svh"

module ols_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ols_pkg::ols_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ols_pkg::ols_out_t out_data_o
);

  // A result word holds until it is taken
  `OLS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed or dropped while stalled")

  // No new input while a print is still streaming entries
  `OLS_ASSERT_NOW(a_busy_mid_print, out_valid_o && !out_data_o.last, !in_ready_o, "input taken while print words remain")

  // Words without an entry are closing words with a zero value
  `OLS_ASSERT_NOW(a_plain_word, out_valid_o && !out_data_o.entry_valid, out_data_o.last && (out_data_o.entry_value == 32'sd0), "non-entry word malformed")

  // Entry words never carry a search or overflow flag
  `OLS_ASSERT_NOW(a_entry_flags, out_valid_o && out_data_o.entry_valid, !out_data_o.found && !out_data_o.overflow, "entry word carries a flag")

  // The sequencer is busy in the cycle after taking an input word
  `OLS_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "ready stayed high after an input word")

endmodule

bind ordered_list_store ols_checker u_ols_checker (.*);
